FILE: hdl/sit_pkg.sv
// Shared types, field widths, register indexes and key ordering for the sorted insert table.
`default_nettype none

package sit_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

  typedef struct packed {
    logic cmp_en;
    logic upd_en;
    logic is_find;
    logic descending;
  } sit_ctl_t;

  // True when key a sits at or beyond key b in the active order.
  function automatic logic at_or_after(input logic signed [KEY_W-1:0] a,
                                       input logic signed [KEY_W-1:0] b,
                                       input logic descending);
    logic res;
    if (descending) begin
      res = (a <= b);
    end else begin
      res = (a >= b);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sit_cell.sv
// One table slot: holds an entry, compares it with the current item and shifts from its neighbor.
`default_nettype none

module sit_cell #(
  parameter int unsigned DEPTH = sit_pkg::DEPTH_DEFAULT,
  parameter int unsigned IDX   = 0
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire sit_pkg::sit_ctl_t               ctl_i,
  input  wire  [$clog2(DEPTH+1)-1:0]           count_i,
  input  wire  [sit_pkg::ID_W-1:0]             item_id_i,
  input  wire  signed [sit_pkg::KEY_W-1:0]     item_key_i,
  input  wire  [sit_pkg::ID_W-1:0]             prev_id_i,
  input  wire  signed [sit_pkg::KEY_W-1:0]     prev_key_i,
  input  wire                                  append_i,
  input  wire                                  before_i,
  output logic [sit_pkg::ID_W-1:0]             id_o,
  output logic signed [sit_pkg::KEY_W-1:0]     key_o,
  output logic                                 app_o,
  output logic                                 first_o,
  output logic                                 before_o
);
  import sit_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [ID_W-1:0]         id_q;
  logic signed [KEY_W-1:0] key_q;
  logic                    hit_q, hit_d;
  logic                    app_q, app_d;
  logic                    occupied, is_last, is_tail, hit_eff;

  assign occupied = (CW'(IDX) < count_i);
  assign is_last  = (CW'(IDX + 1) == count_i);
  assign is_tail  = (CW'(IDX) == count_i);

  always_comb begin
    if (ctl_i.is_find) begin
      hit_d = occupied && (id_q == item_id_i);
    end else begin
      hit_d = occupied && at_or_after(key_q, item_key_i, ctl_i.descending);
    end
    app_d = is_last && at_or_after(item_key_i, key_q, ctl_i.descending);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      app_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      hit_q <= hit_d;
      app_q <= app_d;
    end
  end

  // An insert lands on the first slot at or beyond its key, or on the tail slot.
  always_comb begin
    if (ctl_i.is_find) begin
      hit_eff = hit_q;
    end else begin
      hit_eff = (hit_q && !append_i) || is_tail;
    end
  end

  assign first_o  = hit_eff && !before_i;
  assign before_o = before_i || hit_eff;

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd_en) begin
      if (first_o) begin
        id_q  <= item_id_i;
        key_q <= item_key_i;
      end else if (before_i) begin
        id_q  <= prev_id_i;
        key_q <= prev_key_i;
      end
    end
  end

  assign id_o  = id_q;
  assign key_o = key_q;
  assign app_o = app_q;

endmodule

`default_nettype wire

FILE: hdl/sit_chain.sv
// Row of table cells with the first-hit position and key reduction.
`default_nettype none

module sit_chain #(
  parameter int unsigned DEPTH = sit_pkg::DEPTH_DEFAULT
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire sit_pkg::sit_ctl_t               ctl_i,
  input  wire  [$clog2(DEPTH+1)-1:0]           count_i,
  input  wire  [sit_pkg::ID_W-1:0]             item_id_i,
  input  wire  signed [sit_pkg::KEY_W-1:0]     item_key_i,
  output logic [$clog2(DEPTH)-1:0]             pos_o,
  output logic signed [sit_pkg::KEY_W-1:0]     hit_key_o,
  output logic                                 any_hit_o
);
  import sit_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  logic [ID_W-1:0]         ids  [DEPTH];
  logic signed [KEY_W-1:0] keys [DEPTH];
  logic [DEPTH-1:0]        app;
  logic [DEPTH-1:0]        first;
  logic [DEPTH:0]          seen_hit;
  logic                    append;

  assign seen_hit[0] = 1'b0;
  assign append      = |app;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_W-1:0]         prev_id;
    logic signed [KEY_W-1:0] prev_key;

    if (g == 0) begin : g_head
      assign prev_id  = item_id_i;
      assign prev_key = item_key_i;
    end else begin : g_body
      assign prev_id  = ids[g-1];
      assign prev_key = keys[g-1];
    end

    sit_cell #(
      .DEPTH(DEPTH),
      .IDX  (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .count_i   (count_i),
      .item_id_i (item_id_i),
      .item_key_i(item_key_i),
      .prev_id_i (prev_id),
      .prev_key_i(prev_key),
      .append_i  (append),
      .before_i  (seen_hit[g]),
      .id_o      (ids[g]),
      .key_o     (keys[g]),
      .app_o     (app[g]),
      .first_o   (first[g]),
      .before_o  (seen_hit[g+1])
    );
  end

  // At most one cell reports the first hit, so the encode is a plain OR.
  always_comb begin
    pos_o     = '0;
    hit_key_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos_o     = pos_o | IW'(i);
        hit_key_o = hit_key_o | keys[i];
      end
    end
  end

  assign any_hit_o = seen_hit[DEPTH];

endmodule

`default_nettype wire

FILE: hdl/sorted_insert_table.sv
// Top level of the sorted insert table: stream ports, sequencing, count and result register.
//
//  Channel   Dir  Handshake                      Contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: kind; tdata: entry_id, sort_key
//  m_axis    out  m_axis_tvalid / m_axis_tready  tuser: ok; tdata: slot, found_key, count
//  cfg       in   cfg_we_i (no back-pressure)    cfg_idx_i selects, cfg_data_i is the value
//
// Each transaction has a compare step, in which every cell compares its entry with the
// item and registers a hit, and an update step, in which the first hit is resolved along
// the row of cells, entries shift up by one slot and the result register loads. The next
// transaction is taken in the same cycle as the update, never during a compare step.
// Reset clears the entry count, the state, the configuration and the result valid flag; entry storage is not cleared.
// A result waiting in the output register stalls the update step, not the compare step.
`default_nettype none

module sorted_insert_table #(
  parameter int unsigned DEPTH = sit_pkg::DEPTH_DEFAULT
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Input stream.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] entry_id, [47:16] sort_key.
  input  wire  [sit_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] kind.
  input  wire                                s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [5:0] slot, [37:6] found_key, [44:38] count, [47:45] zero.
  output logic [sit_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] ok.
  output logic                               m_axis_tuser,
  // Configuration writes.
  input  wire                                cfg_we_i,
  input  wire  [sit_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [sit_pkg::CFG_W-1:0]          cfg_data_i
);
  import sit_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic                    kind_q;
  logic [ID_W-1:0]         id_q;
  logic signed [KEY_W-1:0] key_q;
  logic [CW-1:0]           count_q, count_d;
  logic                    desc_q;
  logic [CAP_W-1:0]        cap_q;

  logic                    out_valid_q;
  logic                    out_ok_q, out_ok_d;
  logic [SLOT_W-1:0]       out_slot_q, out_slot_d;
  logic signed [KEY_W-1:0] out_key_q, out_key_d;
  logic [COUNT_W-1:0]      out_count_q;

  logic                    in_acc, fire_upd, full, ins_ok;
  sit_ctl_t                ctl;
  logic [IW-1:0]           pos;
  logic signed [KEY_W-1:0] hit_key;
  logic                    any_hit;

  // The update step may proceed only when the output register is free or draining.
  assign fire_upd      = (state_q == ST_UPD) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) || fire_upd;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Full when the count reaches either the table size or the programmed limit.
  assign full   = (count_q >= CW'(DEPTH)) || (LW'(count_q) >= LW'(cap_q));
  assign ins_ok = (kind_q == KIND_INSERT) && !full;

  always_comb begin
    state_d = state_q;
    if (in_acc) begin
      state_d = ST_CMP;
    end else if (state_q == ST_CMP) begin
      state_d = ST_UPD;
    end else if (fire_upd) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      id_q   <= s_axis_tdata[ID_W-1:0];
      key_q  <= s_axis_tdata[ID_W+KEY_W-1:ID_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q <= 1'b0;
      cap_q  <= CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DESCENDING: desc_q <= cfg_data_i[0];
        REG_CAPACITY:   cap_q  <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign ctl.cmp_en     = (state_q == ST_CMP);
  assign ctl.upd_en     = fire_upd && ins_ok;
  assign ctl.is_find    = (kind_q == KIND_FIND);
  assign ctl.descending = desc_q;

  sit_chain #(
    .DEPTH(DEPTH)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .count_i   (count_q),
    .item_id_i (id_q),
    .item_key_i(key_q),
    .pos_o     (pos),
    .hit_key_o (hit_key),
    .any_hit_o (any_hit)
  );

  assign count_d = ins_ok ? count_q + CW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_upd) begin
      count_q <= count_d;
    end
  end

  // Failed inserts and finds report slot zero and key zero.
  always_comb begin
    if (kind_q == KIND_FIND) begin
      out_ok_d = any_hit;
    end else begin
      out_ok_d = ins_ok;
    end
    out_slot_d = out_ok_d ? SLOT_W'(pos) : '0;
    out_key_d  = ((kind_q == KIND_FIND) && any_hit) ? hit_key : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_upd) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_upd) begin
      out_ok_q    <= out_ok_d;
      out_slot_q  <= out_slot_d;
      out_key_q   <= out_key_d;
      out_count_q <= COUNT_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_key_q, out_slot_q};

  // The entry count never passes the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(DEPTH))
    else $error("entry count exceeds table size");

  // An accepted insert always finds a landing slot in the row of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (fire_upd && ins_ok) |-> any_hit)
    else $error("accepted insert found no slot");

  // An accepted insert raises the count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (fire_upd && ins_ok) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("count did not advance on insert");

  // No new transaction is taken while the cells are comparing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == ST_CMP) |-> !s_axis_tready)
    else $error("input taken during compare step");

endmodule

`default_nettype wire

FILE: tb/sv/sorted_insert_table_tb.sv
// Self-checking stream testbench for the sorted insert table, with a built-in table predictor.
`default_nettype none

module sorted_insert_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEPTH_DEFAULT;

  // One input transaction as the sender sees it.
  typedef struct packed {
    logic                    kind;
    logic [ID_W-1:0]         entry_id;
    logic signed [KEY_W-1:0] sort_key;
  } table_op_t;

  // One result transaction, unpacked from tuser and tdata.
  typedef struct packed {
    logic                    ok;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] found_key;
    logic [COUNT_W-1:0]      count;
  } table_resp_t;

  // Clock, reset and every block input start at known values.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [15:0] entry_id, [47:16] sort_key.
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] kind.
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [5:0] slot, [37:6] found_key, [44:38] count, [47:45] zero.
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] ok.
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;

  sorted_insert_table #(
    .DEPTH(TABLE_DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  // Predicted contents of the table. Only slots below shadow_count are ever read, and
  // those have always been written by an earlier insert.
  logic [ID_W-1:0]         shadow_ids [TABLE_DEPTH];
  logic signed [KEY_W-1:0] shadow_keys[TABLE_DEPTH];
  int unsigned             shadow_count = 0;
  logic                    shadow_descending = 1'b0;
  logic [CAP_W-1:0]        shadow_capacity = CAP_RESET;

  table_op_t   pending_ops[$];    // items not yet offered to the block
  table_resp_t awaited_resps[$];  // results predicted but not yet seen

  bit          in_fire = 1'b0;    // an input transaction completed at the last rising edge
  int unsigned ops_taken = 0;
  int unsigned fail_count = 0;
  int unsigned src_idle_pct = 20;
  int unsigned sink_idle_pct = 20;
  bit          sink_hold = 1'b0;

  // True when key a lies at or beyond key b in the order that is active right now.
  function automatic bit key_reaches(input logic signed [KEY_W-1:0] a,
                                     input logic signed [KEY_W-1:0] b);
    return shadow_descending ? (a <= b) : (a >= b);
  endfunction

  // Applies one item to the predicted table and returns the result it must produce.
  function automatic table_resp_t table_apply(input table_op_t op);
    table_resp_t r;
    int unsigned limit;
    int unsigned pos;
    bit          hit;
    r = '0;
    hit = 1'b0;
    if (op.kind == KIND_INSERT) begin
      // A limit above the table size acts as the table size.
      limit = (shadow_capacity < TABLE_DEPTH) ? shadow_capacity : TABLE_DEPTH;
      if (shadow_count < limit) begin
        pos = shadow_count;
        // Append on a tie with the last entry or beyond it; otherwise go in front of the
        // first entry that sits at or beyond the new key and push the tail up one slot.
        if (shadow_count > 0 && !key_reaches(op.sort_key, shadow_keys[shadow_count-1])) begin
          for (int unsigned i = 0; i < shadow_count; i++) begin
            if (!hit && key_reaches(shadow_keys[i], op.sort_key)) begin
              pos = i;
              hit = 1'b1;
            end
          end
          for (int unsigned i = shadow_count; i > pos; i--) begin
            shadow_ids[i]  = shadow_ids[i-1];
            shadow_keys[i] = shadow_keys[i-1];
          end
        end
        shadow_ids[pos]  = op.entry_id;
        shadow_keys[pos] = op.sort_key;
        shadow_count++;
        r.ok   = 1'b1;
        r.slot = pos[SLOT_W-1:0];
      end
    end else begin
      // The lowest slot with a matching id wins.
      for (int unsigned i = 0; i < shadow_count; i++) begin
        if (!hit && shadow_ids[i] == op.entry_id) begin
          hit = 1'b1;
          r.ok = 1'b1;
          r.slot = i[SLOT_W-1:0];
          r.found_key = shadow_keys[i];
        end
      end
    end
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  // Monitor and predictor. Configuration writes, input transactions and result
  // transactions are all taken at the rising edge, from values that were driven at the
  // preceding falling edge or registered by the block.
  always @(posedge clk_i) begin : watch_table
    table_op_t   op;
    table_resp_t got;
    table_resp_t want;
    in_fire = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DESCENDING) begin
          shadow_descending = cfg_data_i[0];
        end else begin
          shadow_capacity = cfg_data_i[CAP_W-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok        = m_axis_tuser;
        got.slot      = m_axis_tdata[5:0];
        got.found_key = m_axis_tdata[37:6];
        got.count     = m_axis_tdata[44:38];
        if (awaited_resps.size() == 0) begin
          note_mismatch("unexpected result", '0, 64'({m_axis_tuser, m_axis_tdata}));
        end else begin
          want = awaited_resps.pop_front();
          if (got.ok !== want.ok) note_mismatch("ok", 64'(want.ok), 64'(got.ok));
          if (got.slot !== want.slot) note_mismatch("slot", 64'(want.slot), 64'(got.slot));
          if (got.found_key !== want.found_key) begin
            note_mismatch("found_key", 64'(want.found_key), 64'(got.found_key));
          end
          if (got.count !== want.count) begin
            note_mismatch("count", 64'(want.count), 64'(got.count));
          end
          if (m_axis_tdata[47:45] !== 3'b000) begin
            note_mismatch("tdata padding", '0, 64'(m_axis_tdata[47:45]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op.kind     = s_axis_tuser;
        op.entry_id = s_axis_tdata[15:0];
        op.sort_key = s_axis_tdata[47:16];
        awaited_resps.push_back(table_apply(op));
        ops_taken++;
        in_fire = 1'b1;
      end
    end
  end

  // Sender. Once valid is raised it stays up, with the same item, until the block takes it.
  always @(negedge clk_i) begin : send_ops
    table_op_t op;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {op.sort_key, op.entry_id};
        s_axis_tuser  <= op.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. Ready drops at random, and for one long hold-off.
  always @(negedge clk_i) begin : take_results
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // Long hold-off in the middle of a busy phase: the result register fills, the block
  // stops taking input, and the sender keeps offering the whole time.
  initial begin : sink_hold_off
    while (ops_taken < 700) @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Waits until every item has gone through and its result has arrived, then lets the
  // pipeline run dry before anything else happens.
  task automatic settle();
    while (pending_ops.size() != 0 || s_axis_tvalid || awaited_resps.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_op(input logic kind, input int unsigned id, input int key);
    table_op_t op;
    op.kind     = kind;
    op.entry_id = id[ID_W-1:0];
    op.sort_key = key;
    pending_ops.push_back(op);
  endtask

  // Random item. Ids come mostly from a small pool so that finds hit and ids repeat;
  // keys mix the extremes, a narrow band full of ties and the whole range.
  function automatic table_op_t rand_op();
    table_op_t   op;
    int unsigned pick;
    op.kind = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 60) op.entry_id = ID_W'($urandom_range(15));
    else if (pick < 90) op.entry_id = ID_W'($urandom);
    else op.entry_id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    pick = $urandom_range(99);
    if (pick < 30) begin
      case ($urandom_range(4))
        0: op.sort_key = 32'sh8000_0000;
        1: op.sort_key = 32'sh7FFF_FFFF;
        2: op.sort_key = 0;
        3: op.sort_key = -1;
        default: op.sort_key = 1;
      endcase
    end else if (pick < 60) begin
      op.sort_key = int'($urandom_range(16)) - 8;
    end else begin
      op.sort_key = $urandom;
    end
    return op;
  endfunction

  task automatic run_random(input int unsigned descending, input int unsigned capacity,
                            input int unsigned n_ops);
    settle();
    write_reg(REG_DESCENDING, descending);
    write_reg(REG_CAPACITY, capacity);
    for (int unsigned i = 0; i < n_ops; i++) begin
      pending_ops.push_back(rand_op());
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero capacity: every insert is refused, and finds on the empty table miss.
    write_reg(REG_CAPACITY, 0);
    write_reg(REG_DESCENDING, 0);
    queue_op(KIND_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    queue_op(KIND_FIND, 16'h0000, 0);
    queue_op(KIND_FIND, 16'hFFFF, -1);

    // Ascending, room for five: append into an empty table, append beyond the last
    // entry, insert in front of everything, insert on a tie in the middle, append on a
    // tie with the last entry, and then a refusal once the table is full.
    settle();
    write_reg(REG_CAPACITY, 5);
    queue_op(KIND_INSERT, 16'h0001, 0);
    queue_op(KIND_INSERT, 16'h0002, 32'sh7FFF_FFFF);
    queue_op(KIND_INSERT, 16'h0003, 32'sh8000_0000);
    queue_op(KIND_INSERT, 16'h0004, 0);
    queue_op(KIND_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    queue_op(KIND_INSERT, 16'h0006, 5);
    queue_op(KIND_FIND, 16'h0004, 32'sh5555_5555);
    queue_op(KIND_FIND, 16'h0003, 0);
    queue_op(KIND_FIND, 16'hFFFF, 0);
    queue_op(KIND_FIND, 16'h0007, 0);

    // Limit lowered below the count: inserts refused, stored entries kept.
    settle();
    write_reg(REG_CAPACITY, 1);
    queue_op(KIND_INSERT, 16'h0008, -3);
    queue_op(KIND_FIND, 16'h0002, 0);

    // Descending with a limit above the table size; a repeated id is found at its
    // lowest slot.
    settle();
    write_reg(REG_DESCENDING, 1);
    write_reg(REG_CAPACITY, 127);
    queue_op(KIND_INSERT, 16'h0002, 0);
    queue_op(KIND_INSERT, 16'h0009, 32'sh7FFF_FFFF);
    queue_op(KIND_INSERT, 16'h000A, 32'sh8000_0000);
    queue_op(KIND_INSERT, 16'h000B, 32'sh8000_0000);
    queue_op(KIND_FIND, 16'h0002, 0);
    queue_op(KIND_FIND, 16'h000B, 0);

    // Random phases. The first two run with no idling on either side.
    run_random(1, 20, 250);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(0, 40, 250);
    settle();
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    run_random(1, 127, 300);
    run_random(0, 0, 150);
    run_random(0, 64, 300);
    run_random(1, 64, 200);
    settle();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && awaited_resps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
